// ===== design/power_mode_sequencer_macros.svh =====
// assertion helpers for the power mode sequencer
`ifndef POWER_MODE_SEQUENCER_MACROS_SVH
`define POWER_MODE_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("power mode sequencer check failed");

// next-cycle implication, disabled in reset
`define PMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("power mode sequencer check failed");

`endif

// ===== design/pms_pkg.sv =====
`default_nettype none

package pms_pkg;

  localparam int TIMER_WIDTH_DEF = 8;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 8;

  // modes
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_ACCOFF = 2'd1;
  localparam logic [1:0] MODE_PWROFF = 2'd2;
  localparam logic [1:0] MODE_PWRON  = 2'd3;

  // items
  localparam logic [3:0] ITEM_HOLD       = 4'd0;
  localparam logic [3:0] ITEM_HOLD_IN    = 4'd1;
  localparam logic [3:0] ITEM_HOLD_OUT   = 4'd2;
  localparam logic [3:0] ITEM_ACCOFF     = 4'd3;
  localparam logic [3:0] ITEM_ACCOFF_IN  = 4'd4;
  localparam logic [3:0] ITEM_ACCOFF_OUT = 4'd5;
  localparam logic [3:0] ITEM_PWROFF     = 4'd6;
  localparam logic [3:0] ITEM_PWRON_OUT  = 4'd7;
  localparam logic [3:0] ITEM_PWRON_IN   = 4'd8;
  localparam logic [3:0] ITEM_PWRON      = 4'd9;

  // messages
  localparam logic [2:0] MSG_NONE        = 3'd0;
  localparam logic [2:0] MSG_HOLD_IN     = 3'd1;
  localparam logic [2:0] MSG_HOLD_OUT    = 3'd2;
  localparam logic [2:0] MSG_OFF_REQUEST = 3'd3;
  localparam logic [2:0] MSG_MAIN_OFF    = 3'd4;
  localparam logic [2:0] MSG_MAIN_ON     = 3'd5;
  localparam logic [2:0] MSG_POWER_OFF   = 3'd6;
  localparam logic [2:0] MSG_POWER_ON    = 3'd7;

  // port actions
  localparam logic [1:0] PA_NONE         = 2'd0;
  localparam logic [1:0] PA_ENTER_HOLD   = 2'd1;
  localparam logic [1:0] PA_ENTER_ACCOFF = 2'd2;
  localparam logic [1:0] PA_LEAVE_ACCOFF = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCOFF_DELAY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWROFF_DELAY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWRON_DELAY  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_ENABLE  = 2'd3;

  localparam logic [CFG_DATA_W-1:0] ACCOFF_DELAY_RST = 8'd31;
  localparam logic [CFG_DATA_W-1:0] PWROFF_DELAY_RST = 8'd11;
  localparam logic [CFG_DATA_W-1:0] PWRON_DELAY_RST  = 8'd51;

  // item by [target][current]
  localparam logic [3:0] ITEM_TABLE [4][4] = '{
    '{ITEM_HOLD,     ITEM_HOLD_IN,    ITEM_ACCOFF_IN, ITEM_PWRON_OUT},
    '{ITEM_HOLD_OUT, ITEM_ACCOFF,     ITEM_ACCOFF_IN, ITEM_PWRON_OUT},
    '{ITEM_HOLD_OUT, ITEM_ACCOFF_OUT, ITEM_PWROFF,    ITEM_PWRON_OUT},
    '{ITEM_HOLD_OUT, ITEM_ACCOFF_OUT, ITEM_PWRON_IN,  ITEM_PWRON}
  };

  typedef enum logic [1:0] {
    STEP_END    = 2'd0,
    STEP_FIRST  = 2'd1,
    STEP_SECOND = 2'd2
  } seq_step_t;

  typedef struct packed {
    logic key;
    logic mute;
    logic bus;
    logic stby;
    logic sys;
  } pins_t;

endpackage

`default_nettype wire

// ===== design/power_mode_sequencer.sv =====
// channel | direction | handshake            | payload
// in_     | request   | in_valid / in_ready   | nine poll flags
// out_    | response  | out_valid / out_ready | modes, item, message, pins, pulses
// cfg_    | write     | cfg_we                | cfg_index, cfg_wdata
//
// one request per cycle unless out_ready stalls; result the cycle after acceptance
// whole poll (both selection passes) is one combinational step into the result register
// in_ready stays high while the result register is empty or being drained
// synchronous active-low reset: acc-off mode, pin state all low, default delays
`default_nettype none

`include "power_mode_sequencer_macros.svh"

module power_mode_sequencer #(
  parameter int TIMER_WIDTH = pms_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             in_wake_request,
  input  wire logic                             in_acc_on,
  input  wire logic                             in_alarm_adjusting,
  input  wire logic                             in_power_key_on,
  input  wire logic                             in_acc_det_high,
  input  wire logic                             in_display_update_done,
  input  wire logic                             in_ms_tick,
  input  wire logic                             in_acc_debounce_done,
  input  wire logic                             in_alarm_detect_set,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [1:0]                       out_current_mode,
  output      logic [1:0]                       out_target_mode,
  output      logic [3:0]                       out_item_done,
  output      logic [2:0]                       out_message,
  output      logic                             out_system_on_pin,
  output      logic                             out_standby_pin,
  output      logic                             out_bus_enable,
  output      logic                             out_audio_mute,
  output      logic                             out_key_scan_on,
  output      logic [1:0]                       out_port_action,
  output      logic                             out_alarm_beep,
  input  wire logic                             cfg_we,
  input  wire logic [pms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pms_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pms_pkg::*;

  logic [CFG_DATA_W-1:0]  accoff_delay_r, pwroff_delay_r, pwron_delay_r;
  logic                   hold_enable_r;

  logic [1:0]             cur_mode_r, cur_mode_nxt;
  logic [1:0]             tar_mode_r, tar_mode_nxt;
  seq_step_t              seq_step_r, seq_step_nxt;
  logic [3:0]             cur_item_r, cur_item_nxt;
  logic                   item_change_ok_r, item_change_ok_nxt;
  logic                   acc_normal_r, acc_normal_nxt;
  logic                   acc_detect_active_r, acc_detect_active_nxt;
  logic                   alarm_detect_active_r, alarm_detect_active_nxt;
  logic [TIMER_WIDTH-1:0] delay_timer_r, delay_timer_nxt;
  pins_t                  pins_r, pins_nxt;
  logic [2:0]             msg_nxt;
  logic [1:0]             port_nxt;
  logic                   beep_nxt;

  logic                   out_valid_r;
  logic [1:0]             out_current_mode_r, out_target_mode_r, out_port_action_r;
  logic [3:0]             out_item_done_r;
  logic [2:0]             out_message_r;
  pins_t                  out_pins_r;
  logic                   out_alarm_beep_r;

  logic                   in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accoff_delay_r <= ACCOFF_DELAY_RST;
      pwroff_delay_r <= PWROFF_DELAY_RST;
      pwron_delay_r  <= PWRON_DELAY_RST;
      hold_enable_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCOFF_DELAY: accoff_delay_r <= cfg_wdata;
        CFG_PWROFF_DELAY: pwroff_delay_r <= cfg_wdata;
        CFG_PWRON_DELAY:  pwron_delay_r  <= cfg_wdata;
        CFG_HOLD_ENABLE:  hold_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // one poll: timer and flags, then up to two selection passes
  always_comb begin
    logic [1:0] tgt;
    logic       go;
    logic       again;

    cur_mode_nxt            = cur_mode_r;
    tar_mode_nxt            = tar_mode_r;
    seq_step_nxt            = seq_step_r;
    cur_item_nxt            = cur_item_r;
    item_change_ok_nxt      = item_change_ok_r;
    acc_normal_nxt          = acc_normal_r;
    acc_detect_active_nxt   = acc_detect_active_r;
    alarm_detect_active_nxt = alarm_detect_active_r;
    delay_timer_nxt         = delay_timer_r;
    pins_nxt                = pins_r;
    msg_nxt                 = MSG_NONE;
    port_nxt                = PA_NONE;
    beep_nxt                = 1'b0;
    go                      = 1'b1;
    again                   = 1'b0;
    tgt                     = MODE_ACCOFF;

    if (in_ms_tick && (delay_timer_nxt != '0)) begin
      delay_timer_nxt = delay_timer_nxt - TIMER_WIDTH'(1);
    end
    if (in_acc_debounce_done) begin
      acc_detect_active_nxt = 1'b0;
    end
    if (in_alarm_detect_set) begin
      alarm_detect_active_nxt = 1'b1;
    end

    for (int p = 0; p < 2; p++) begin
      if (go) begin
        if (in_wake_request) begin
          tgt = MODE_PWRON;
        end else if (in_acc_on || in_alarm_adjusting) begin
          tgt = in_power_key_on ? MODE_PWRON : MODE_PWROFF;
        end else if (hold_enable_r && !acc_normal_nxt && !acc_detect_active_nxt &&
                     !alarm_detect_active_nxt) begin
          tgt = MODE_HOLD;
        end else begin
          tgt = MODE_ACCOFF;
        end
        if ((tgt != tar_mode_nxt) && item_change_ok_nxt) begin
          tar_mode_nxt = tgt;
          seq_step_nxt = STEP_END;
        end
        if (seq_step_nxt == STEP_END) begin
          item_change_ok_nxt = 1'b0;
          cur_item_nxt       = ITEM_TABLE[tar_mode_nxt][cur_mode_nxt];
          seq_step_nxt       = STEP_FIRST;
        end
        again = 1'b0;
        case (cur_item_nxt)
          ITEM_HOLD: begin
            acc_normal_nxt     = 1'b1;
            seq_step_nxt       = STEP_END;
            item_change_ok_nxt = 1'b1;
            again              = 1'b1;
          end
          ITEM_HOLD_IN: begin
            case (seq_step_nxt)
              STEP_FIRST: begin
                msg_nxt      = MSG_HOLD_IN;
                seq_step_nxt = STEP_SECOND;
              end
              STEP_SECOND: begin
                cur_mode_nxt            = MODE_HOLD;
                seq_step_nxt            = STEP_END;
                alarm_detect_active_nxt = 1'b0;
                if (in_acc_det_high) begin
                  port_nxt = PA_ENTER_HOLD;
                end else begin
                  acc_normal_nxt        = 1'b1;
                  acc_detect_active_nxt = 1'b1;
                end
                item_change_ok_nxt = 1'b1;
              end
              default: seq_step_nxt = STEP_END;
            endcase
          end
          ITEM_HOLD_OUT: begin
            msg_nxt            = MSG_HOLD_OUT;
            cur_mode_nxt       = MODE_ACCOFF;
            seq_step_nxt       = STEP_END;
            item_change_ok_nxt = 1'b1;
          end
          ITEM_ACCOFF: begin
            item_change_ok_nxt = 1'b1;
            if (!acc_detect_active_nxt && !alarm_detect_active_nxt &&
                !in_display_update_done) begin
              acc_normal_nxt = 1'b0;
            end
          end
          ITEM_ACCOFF_IN: begin
            case (seq_step_nxt)
              STEP_FIRST: begin
                msg_nxt         = MSG_OFF_REQUEST;
                delay_timer_nxt = TIMER_WIDTH'(accoff_delay_r);
                seq_step_nxt    = STEP_SECOND;
              end
              STEP_SECOND: begin
                if (delay_timer_nxt == '0) begin
                  pins_nxt.sys = 1'b0;
                  pins_nxt.bus = 1'b0;
                  cur_mode_nxt = MODE_ACCOFF;
                  seq_step_nxt = STEP_END;
                  msg_nxt      = MSG_MAIN_OFF;
                  pins_nxt.key = 1'b1;
                  port_nxt     = PA_ENTER_ACCOFF;
                end
              end
              default: seq_step_nxt = STEP_END;
            endcase
          end
          ITEM_ACCOFF_OUT: begin
            case (seq_step_nxt)
              STEP_FIRST: begin
                port_nxt     = PA_LEAVE_ACCOFF;
                seq_step_nxt = STEP_SECOND;
              end
              STEP_SECOND: begin
                pins_nxt.sys = 1'b1;
                pins_nxt.bus = 1'b1;
                msg_nxt      = MSG_MAIN_ON;
                seq_step_nxt = STEP_END;
                cur_mode_nxt = MODE_PWROFF;
              end
              default: seq_step_nxt = STEP_END;
            endcase
          end
          ITEM_PWROFF: begin
            item_change_ok_nxt = 1'b1;
            seq_step_nxt       = STEP_END;
            pins_nxt.key       = 1'b1;
          end
          ITEM_PWRON_OUT: begin
            case (seq_step_nxt)
              STEP_FIRST: begin
                item_change_ok_nxt = 1'b0;
                pins_nxt.mute      = 1'b1;
                delay_timer_nxt    = TIMER_WIDTH'(pwroff_delay_r);
                pins_nxt.key       = 1'b0;
                seq_step_nxt       = STEP_SECOND;
              end
              STEP_SECOND: begin
                if (delay_timer_nxt == '0) begin
                  msg_nxt            = MSG_POWER_OFF;
                  pins_nxt.key       = 1'b1;
                  pins_nxt.stby      = 1'b0;
                  cur_mode_nxt       = MODE_PWROFF;
                  seq_step_nxt       = STEP_END;
                  item_change_ok_nxt = 1'b1;
                end
              end
              default: seq_step_nxt = STEP_END;
            endcase
          end
          ITEM_PWRON_IN: begin
            case (seq_step_nxt)
              STEP_FIRST: begin
                msg_nxt         = MSG_POWER_ON;
                pins_nxt.key    = 1'b0;
                delay_timer_nxt = TIMER_WIDTH'(pwron_delay_r);
                seq_step_nxt    = STEP_SECOND;
              end
              STEP_SECOND: begin
                if (delay_timer_nxt == '0) begin
                  pins_nxt.stby = 1'b1;
                  if (in_wake_request) begin
                    beep_nxt = 1'b1;
                  end
                  pins_nxt.key  = 1'b1;
                  pins_nxt.mute = 1'b0;
                  seq_step_nxt  = STEP_END;
                  cur_mode_nxt  = MODE_PWRON;
                end
              end
              default: seq_step_nxt = STEP_END;
            endcase
          end
          default: begin
            seq_step_nxt       = STEP_END;
            pins_nxt.key       = 1'b1;
            item_change_ok_nxt = 1'b1;
          end
        endcase
        go = again;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r            <= MODE_ACCOFF;
      tar_mode_r            <= MODE_HOLD;
      seq_step_r            <= STEP_END;
      cur_item_r            <= ITEM_HOLD;
      item_change_ok_r      <= 1'b1;
      acc_normal_r          <= 1'b1;
      acc_detect_active_r   <= 1'b1;
      alarm_detect_active_r <= 1'b0;
      delay_timer_r         <= '0;
      pins_r                <= '0;
    end else if (in_fire) begin
      cur_mode_r            <= cur_mode_nxt;
      tar_mode_r            <= tar_mode_nxt;
      seq_step_r            <= seq_step_nxt;
      cur_item_r            <= cur_item_nxt;
      item_change_ok_r      <= item_change_ok_nxt;
      acc_normal_r          <= acc_normal_nxt;
      acc_detect_active_r   <= acc_detect_active_nxt;
      alarm_detect_active_r <= alarm_detect_active_nxt;
      delay_timer_r         <= delay_timer_nxt;
      pins_r                <= pins_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_current_mode_r <= cur_mode_nxt;
      out_target_mode_r  <= tar_mode_nxt;
      out_item_done_r    <= cur_item_nxt;
      out_message_r      <= msg_nxt;
      out_pins_r         <= pins_nxt;
      out_port_action_r  <= port_nxt;
      out_alarm_beep_r   <= beep_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_mode  = out_current_mode_r;
  assign out_target_mode   = out_target_mode_r;
  assign out_item_done     = out_item_done_r;
  assign out_message       = out_message_r;
  assign out_system_on_pin = out_pins_r.sys;
  assign out_standby_pin   = out_pins_r.stby;
  assign out_bus_enable    = out_pins_r.bus;
  assign out_audio_mute    = out_pins_r.mute;
  assign out_key_scan_on   = out_pins_r.key;
  assign out_port_action   = out_port_action_r;
  assign out_alarm_beep    = out_alarm_beep_r;

  `PMS_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r)
  `PMS_ASSERT_NOW(a_hold_port_in_hold,
    out_valid_r && (out_port_action_r == PA_ENTER_HOLD), out_current_mode_r == MODE_HOLD)
  `PMS_ASSERT_NOW(a_accoff_port_in_accoff,
    out_valid_r && (out_port_action_r == PA_ENTER_ACCOFF),
    (out_current_mode_r == MODE_ACCOFF) && !out_pins_r.sys && out_pins_r.key)
  `PMS_ASSERT_NOW(a_beep_with_power_on,
    out_valid_r && out_alarm_beep_r,
    (out_current_mode_r == MODE_PWRON) && out_pins_r.stby && !out_pins_r.mute)
  `PMS_ASSERT_NOW(a_power_off_msg,
    out_valid_r && (out_message_r == MSG_POWER_OFF),
    (out_current_mode_r == MODE_PWROFF) && !out_pins_r.stby && out_pins_r.key)

endmodule

`default_nettype wire
